[rtl/pis_pkg.sv]
// Shared types, constants and helpers for the particle integration step.
package pis_pkg;

  // Fixed-point format and attractor table size
  localparam int FRAC    = 16;
  localparam int SLOTS   = 8;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int KW      = $clog2(SLOTS + 1);
  localparam int ONE     = 1 << FRAC;
  localparam int EPS_RND = (ONE + 5000) / 10000;
  localparam int EPS     = (EPS_RND > 0) ? EPS_RND : 1;
  localparam int DIVW    = 32 + FRAC;
  localparam int ATT_W   = 40;
  localparam int ASH     = 2 * FRAC - 16;
  localparam int SQ_LAST = 31;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GRAV_X    = 3'd0,
    REG_GRAV_Y    = 3'd1,
    REG_GRAV_Z    = 3'd2,
    REG_LIN_DAMP  = 3'd3,
    REG_QUAD_DAMP = 3'd4,
    REG_MAX_LIFE  = 3'd5,
    REG_ATT_COUNT = 3'd6
  } cfg_idx_t;

  // Command codes
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  typedef struct packed {
    logic               command;
    logic [2:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [30:0]        age;
    logic signed [31:0] strength;
    logic [30:0]        time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic [30:0]        new_age;
    logic [15:0]        alpha;
    logic               expired;
  } out_item_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_V_SQ, ST_V_ACC, ST_V_SQRT, ST_C_MUL, ST_C_USE,
    ST_D_CALC, ST_D_SQ, ST_D_ACC, ST_D_SQRT, ST_D_CHK,
    ST_M_DIV, ST_M_USE, ST_U_DIV, ST_U_MUL, ST_U_ACC, ST_NEXT,
    ST_F_DMUL, ST_F_ACC, ST_F_AMUL, ST_F_VEL, ST_F_PMUL, ST_F_POS,
    ST_A_DIV, ST_A_SQ, ST_A_USE, ST_DONE
  } state_t;

  // Saturate a wide signed value to 32-bit signed
  function automatic logic signed [31:0] sat_s32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -66'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Magnitude of a 32-bit signed value
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

endpackage

[rtl/pis_in_if.sv]
// Input channel: valid/ready handshake with one particle or attractor item.
interface pis_in_if import pis_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/pis_out_if.sv]
// Result channel: valid/ready handshake with one updated particle.
interface pis_out_if import pis_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/particle_integration_step.sv]
// Particle integration step: sequencer around a shared multiplier, divider and square root.
//
//   channel   dir  handshake       payload
//   in_ch     in   valid/ready     in_item_t (update or attractor write)
//   out_ch    out  valid/ready     out_item_t (updated particle)
//   cfg_*     in   cfg_we          cfg_index, cfg_data
//
// An attractor write is stored while idle and the block stays idle. An update
// runs the 32-step square root and the 48-step restoring divider (four
// divisions per active attractor, none for one nearer than epsilon).
// in_ch.ready is high only while idle.
// A finished result waits in the output register; a new item may be taken
// meanwhile. Reset is synchronous, active low, and clears the table.
module particle_integration_step import pis_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pis_in_if.sink      in_ch,
  pis_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  state_t state_r, state_nxt;

  // Configuration registers
  logic signed [31:0] grav_r [3];
  logic [30:0]        lin_damp_r, quad_damp_r, max_life_r;
  logic [3:0]         att_count_r;

  // Attractor table
  logic signed [31:0] ax_r [SLOTS];
  logic signed [31:0] ay_r [SLOTS];
  logic signed [31:0] az_r [SLOTS];
  logic signed [31:0] as_r [SLOTS];

  // Item working registers
  logic signed [31:0]      p_r [3];
  logic signed [31:0]      v_r [3];
  logic signed [31:0]      d_r [3];
  logic signed [ATT_W-1:0] att_r [3];
  logic signed [31:0]      nv_r [3];
  logic signed [31:0]      np_r [3];
  logic signed [31:0]      acc_r, mag_r;
  logic [30:0]             dt_r, new_age_r, coeff_r;
  logic [31:0]             dist_r;
  logic [15:0]             alpha_r;
  logic [63:0]             sum_r;
  logic [1:0]              j_r;
  logic [KW-1:0]           k_r;
  logic [5:0]              cnt_r;

  // Shared units
  logic signed [32:0]      mul_a, mul_b;
  logic signed [65:0]      prod_r;
  logic [63:0]             sq_x_r, sq_res_r, sq_bit_r;
  logic [31:0]             dv_rem_r, dv_den_r;
  logic [DIVW-1:0]         dv_quo_r;

  // Output register
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic                    in_xfer, out_free, sq_done, dv_done;
  logic [KW-1:0]           n_lim, k_inc;
  logic [SLOT_W-1:0]       k_idx;
  logic [1:0]              j_inc;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign sq_done  = (cnt_r == 6'(SQ_LAST));
  assign dv_done  = (cnt_r == 6'(DIVW - 1));
  assign n_lim    = (32'(att_count_r) > SLOTS) ? KW'(SLOTS) : KW'(att_count_r);
  assign k_inc    = k_r + KW'(1);
  assign k_idx    = k_r[SLOT_W-1:0];
  assign j_inc    = j_r + 2'd1;

  // Square root step
  logic [63:0] sq_trial, sq_x_nxt, sq_res_nxt;
  always_comb begin
    sq_trial = sq_res_r + sq_bit_r;
    if (sq_x_r >= sq_trial) begin
      sq_x_nxt   = sq_x_r - sq_trial;
      sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
    end else begin
      sq_x_nxt   = sq_x_r;
      sq_res_nxt = sq_res_r >> 1;
    end
  end

  // Restoring division step
  logic [32:0] dv_sh, dv_diff;
  logic        dv_ge;
  always_comb begin
    dv_sh   = {dv_rem_r, dv_quo_r[DIVW-1]};
    dv_diff = dv_sh - {1'b0, dv_den_r};
    dv_ge   = (dv_sh >= {1'b0, dv_den_r});
  end

  // Quotient interpretations
  logic signed [65:0] quo_w, mag_w;
  logic signed [32:0] unit_w, a_w;
  always_comb begin
    quo_w  = $signed({{(66 - DIVW){1'b0}}, dv_quo_r});
    mag_w  = as_r[k_idx][31] ? -quo_w : quo_w;
    unit_w = d_r[j_r][31] ? -$signed({1'b0, dv_quo_r[31:0]})
                          : $signed({1'b0, dv_quo_r[31:0]});
    if (dv_quo_r > DIVW'(2 * ONE)) a_w = -33'sd1 * 33'(ONE);
    else a_w = 33'(ONE) - $signed({1'b0, dv_quo_r[31:0]});
  end

  // Wide sums for the drag coefficient and the final phase
  logic signed [65:0] grav_w, acc_w, vel_w, pos_w, coeff_w;
  logic signed [65:0] prod_sh;
  always_comb begin
    prod_sh = prod_r >>> FRAC;
    grav_w  = 66'(grav_r[j_r]);
    acc_w   = grav_w + 66'(att_r[j_r]) - prod_sh;
    vel_w   = 66'(v_r[j_r]) + prod_sh;
    pos_w   = 66'(p_r[j_r]) + prod_sh;
    coeff_w = $signed({35'b0, lin_damp_r}) + prod_sh;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_xfer && in_ch.data.command == CMD_UPDATE) state_nxt = ST_V_SQ;
      ST_V_SQ:   state_nxt = ST_V_ACC;
      ST_V_ACC:  state_nxt = (j_r == 2'd2) ? ST_V_SQRT : ST_V_SQ;
      ST_V_SQRT: if (sq_done) state_nxt = ST_C_MUL;
      ST_C_MUL:  state_nxt = ST_C_USE;
      ST_C_USE:  state_nxt = (n_lim == '0) ? ST_F_DMUL : ST_D_CALC;
      ST_D_CALC: state_nxt = ST_D_SQ;
      ST_D_SQ:   state_nxt = ST_D_ACC;
      ST_D_ACC:  state_nxt = (j_r == 2'd2) ? ST_D_SQRT : ST_D_SQ;
      ST_D_SQRT: if (sq_done) state_nxt = ST_D_CHK;
      ST_D_CHK:  state_nxt = (sq_res_r < 64'(EPS)) ? ST_NEXT : ST_M_DIV;
      ST_M_DIV:  if (dv_done) state_nxt = ST_M_USE;
      ST_M_USE:  state_nxt = ST_U_DIV;
      ST_U_DIV:  if (dv_done) state_nxt = ST_U_MUL;
      ST_U_MUL:  state_nxt = ST_U_ACC;
      ST_U_ACC:  state_nxt = (j_r == 2'd2) ? ST_NEXT : ST_U_DIV;
      ST_NEXT:   state_nxt = (k_inc == n_lim) ? ST_F_DMUL : ST_D_CALC;
      ST_F_DMUL: state_nxt = ST_F_ACC;
      ST_F_ACC:  state_nxt = ST_F_AMUL;
      ST_F_AMUL: state_nxt = ST_F_VEL;
      ST_F_VEL:  state_nxt = ST_F_PMUL;
      ST_F_PMUL: state_nxt = ST_F_POS;
      ST_F_POS:  state_nxt = (j_r == 2'd2) ? ST_A_DIV : ST_F_DMUL;
      ST_A_DIV:  if (dv_done) state_nxt = ST_A_SQ;
      ST_A_SQ:   state_nxt = ST_A_USE;
      ST_A_USE:  state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Multiplier operands and handshake outputs
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_V_SQ:   begin mul_a = 33'(v_r[j_r]); mul_b = 33'(v_r[j_r]); end
      ST_C_MUL:  begin
        mul_a = $signed({2'b0, quad_damp_r});
        mul_b = $signed({1'b0, sq_res_r[31:0]});
      end
      ST_D_SQ:   begin mul_a = 33'(d_r[j_r]); mul_b = 33'(d_r[j_r]); end
      ST_U_MUL:  begin mul_a = 33'(mag_r); mul_b = unit_w; end
      ST_F_DMUL: begin mul_a = $signed({2'b0, coeff_r}); mul_b = 33'(v_r[j_r]); end
      ST_F_AMUL: begin mul_a = 33'(acc_r); mul_b = $signed({2'b0, dt_r}); end
      ST_F_PMUL: begin mul_a = 33'(nv_r[j_r]); mul_b = $signed({2'b0, dt_r}); end
      ST_A_SQ:   begin mul_a = a_w; mul_b = a_w; end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Control registers, configuration and attractor table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
      for (int i = 0; i < 3; i++) grav_r[i] <= '0;
      lin_damp_r  <= '0;
      quad_damp_r <= '0;
      max_life_r  <= 31'(ONE);
      att_count_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        ax_r[i] <= '0;
        ay_r[i] <= '0;
        az_r[i] <= '0;
        as_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // loop counter runs inside the iterative states
      if (state_r == ST_V_SQRT || state_r == ST_D_SQRT || state_r == ST_M_DIV ||
          state_r == ST_U_DIV || state_r == ST_A_DIV) begin
        cnt_r <= cnt_r + 6'd1;
      end else begin
        cnt_r <= '0;
      end

      // component index
      priority case (state_r)
        ST_IDLE, ST_C_USE, ST_D_CALC, ST_M_USE, ST_NEXT: j_r <= '0;
        ST_V_ACC, ST_D_ACC, ST_U_ACC, ST_F_POS:          j_r <= j_inc;
        default:                                         j_r <= j_r;
      endcase

      // attractor index
      if (state_r == ST_C_USE) k_r <= '0;
      else if (state_r == ST_NEXT) k_r <= k_inc;

      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          REG_GRAV_X:    grav_r[0]   <= cfg_data;
          REG_GRAV_Y:    grav_r[1]   <= cfg_data;
          REG_GRAV_Z:    grav_r[2]   <= cfg_data;
          REG_LIN_DAMP:  lin_damp_r  <= cfg_data[30:0];
          REG_QUAD_DAMP: quad_damp_r <= cfg_data[30:0];
          REG_MAX_LIFE:  max_life_r  <= cfg_data[30:0];
          REG_ATT_COUNT: att_count_r <= cfg_data[3:0];
          default: ;
        endcase
      end

      // attractor entry write
      if (in_xfer && in_ch.data.command == CMD_WRITE && 32'(in_ch.data.slot) < SLOTS) begin
        ax_r[in_ch.data.slot[SLOT_W-1:0]] <= in_ch.data.pos_x;
        ay_r[in_ch.data.slot[SLOT_W-1:0]] <= in_ch.data.pos_y;
        az_r[in_ch.data.slot[SLOT_W-1:0]] <= in_ch.data.pos_z;
        as_r[in_ch.data.slot[SLOT_W-1:0]] <= in_ch.data.strength;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: begin
        p_r[0] <= in_ch.data.pos_x;
        p_r[1] <= in_ch.data.pos_y;
        p_r[2] <= in_ch.data.pos_z;
        v_r[0] <= in_ch.data.vel_x;
        v_r[1] <= in_ch.data.vel_y;
        v_r[2] <= in_ch.data.vel_z;
        dt_r   <= in_ch.data.time_step;
        begin
          logic [31:0] age_sum;
          age_sum = {1'b0, in_ch.data.age} + {1'b0, in_ch.data.time_step};
          new_age_r <= age_sum[31] ? 31'h7FFF_FFFF : age_sum[30:0];
        end
        for (int i = 0; i < 3; i++) att_r[i] <= '0;
        sum_r <= '0;
      end
      ST_V_ACC, ST_D_ACC: begin
        sum_r    <= sum_r + prod_r[63:0];
        sq_x_r   <= sum_r + prod_r[63:0];
        sq_res_r <= '0;
        sq_bit_r <= 64'h4000_0000_0000_0000;
      end
      ST_V_SQRT, ST_D_SQRT: begin
        sq_x_r   <= sq_x_nxt;
        sq_res_r <= sq_res_nxt;
        sq_bit_r <= sq_bit_r >> 2;
      end
      ST_C_USE: begin
        coeff_r <= (coeff_w > 66'sd2147483647) ? 31'h7FFF_FFFF : coeff_w[30:0];
      end
      ST_D_CALC: begin
        d_r[0] <= sat_s32(66'(ax_r[k_idx]) - 66'(p_r[0]));
        d_r[1] <= sat_s32(66'(ay_r[k_idx]) - 66'(p_r[1]));
        d_r[2] <= sat_s32(66'(az_r[k_idx]) - 66'(p_r[2]));
        sum_r  <= '0;
      end
      ST_D_CHK: begin
        dist_r   <= sq_res_r[31:0];
        dv_rem_r <= '0;
        dv_den_r <= sq_res_r[31:0];
        dv_quo_r <= {abs32(as_r[k_idx]), {FRAC{1'b0}}};
      end
      ST_M_DIV, ST_U_DIV, ST_A_DIV: begin
        dv_rem_r <= dv_ge ? dv_diff[31:0] : dv_sh[31:0];
        dv_quo_r <= {dv_quo_r[DIVW-2:0], dv_ge};
      end
      ST_M_USE: begin
        mag_r    <= sat_s32(mag_w);
        dv_rem_r <= '0;
        dv_den_r <= dist_r;
        dv_quo_r <= {abs32(d_r[0]), {FRAC{1'b0}}};
      end
      ST_U_ACC: begin
        att_r[j_r] <= att_r[j_r] + prod_sh[ATT_W-1:0];
        dv_rem_r   <= '0;
        dv_den_r   <= dist_r;
        dv_quo_r   <= {abs32(d_r[j_inc]), {FRAC{1'b0}}};
      end
      ST_F_ACC: acc_r       <= sat_s32(acc_w);
      ST_F_VEL: nv_r[j_r]   <= sat_s32(vel_w);
      ST_F_POS: begin
        np_r[j_r] <= sat_s32(pos_w);
        dv_rem_r  <= '0;
        dv_den_r  <= (max_life_r == '0) ? 32'd1 : {1'b0, max_life_r};
        dv_quo_r  <= {1'b0, new_age_r, {FRAC{1'b0}}};
      end
      ST_A_USE: begin
        alpha_r <= ((prod_r >>> ASH) > 66'sd65535) ? 16'hFFFF : prod_r[ASH+15:ASH];
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_r.new_pos_x <= np_r[0];
          out_data_r.new_pos_y <= np_r[1];
          out_data_r.new_pos_z <= np_r[2];
          out_data_r.new_vel_x <= nv_r[0];
          out_data_r.new_vel_y <= nv_r[1];
          out_data_r.new_vel_z <= nv_r[2];
          out_data_r.new_age   <= new_age_r;
          out_data_r.alpha     <= alpha_r;
          out_data_r.expired   <= (new_age_r > max_life_r);
        end
      end
      default: ;
    endcase
  end

endmodule

[dv/testbench.sv]
// Testbench for particle_integration_step: directed table plus random traffic checked by a predictor.
module testbench;
  import pis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam longint U31_HI = 64'sd2147483647;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic signed [31:0] gx, gy, gz;
    logic [30:0]        lin, quad, life;
    logic [3:0]         cnt;
  } setting_t;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
    int        ph;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  pis_in_if  in_ch ();
  pis_out_if out_ch ();

  particle_integration_step dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Predictor copy of the configuration and attractor table
  longint grav [3];
  longint lin_damp, quad_damp, life_max;
  int     att_used;
  longint tab_x [SLOTS], tab_y [SLOTS], tab_z [SLOTS], tab_s [SLOTS];

  out_item_t particle_q [$];
  int  nerr = 0;
  bit  hold_req = 1'b0;
  row_t rows [$];

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned sqmag(longint v);
    longint unsigned a;
    a = v < 0 ? longint'(-v) : v;
    return a * a;
  endfunction

  // One frame of particle motion, age and fade
  function automatic out_item_t advance_particle(in_item_t it);
    longint p [3], v [3], att [3], d [3], nv [3], np [3];
    longint age, dt, coeff, na, life, ratio, a, alpha, dlen, mag, unit, damp, acc;
    longint unsigned spd;
    int n;
    out_item_t o;
    p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
    v[0] = it.vel_x; v[1] = it.vel_y; v[2] = it.vel_z;
    att[0] = 0; att[1] = 0; att[2] = 0;
    age = {33'd0, it.age};
    dt = {33'd0, it.time_step};
    na = sat(age + dt, 0, U31_HI);
    spd = isqrt(sqmag(v[0]) + sqmag(v[1]) + sqmag(v[2]));
    coeff = lin_damp + ((quad_damp * longint'(spd)) >>> FRAC);
    if (coeff > S32_HI) coeff = S32_HI;
    n = att_used > SLOTS ? SLOTS : att_used;
    for (int k = 0; k < n; k++) begin
      d[0] = sat(tab_x[k] - p[0], S32_LO, S32_HI);
      d[1] = sat(tab_y[k] - p[1], S32_LO, S32_HI);
      d[2] = sat(tab_z[k] - p[2], S32_LO, S32_HI);
      dlen = longint'(isqrt(sqmag(d[0]) + sqmag(d[1]) + sqmag(d[2])));
      if (dlen < EPS) continue;
      mag = sat(tab_s[k] * ONE / dlen, S32_LO, S32_HI);
      for (int j = 0; j < 3; j++) begin
        unit = d[j] * ONE / dlen;
        att[j] += (mag * unit) >>> FRAC;
      end
    end
    for (int j = 0; j < 3; j++) begin
      damp = (coeff * v[j]) >>> FRAC;
      acc = sat(grav[j] + att[j] - damp, S32_LO, S32_HI);
      nv[j] = sat(v[j] + ((acc * dt) >>> FRAC), S32_LO, S32_HI);
      np[j] = sat(p[j] + ((nv[j] * dt) >>> FRAC), S32_LO, S32_HI);
    end
    life = life_max > 0 ? life_max : 1;
    ratio = na * ONE / life;
    a = sat(ONE - ratio, -ONE, ONE);
    alpha = (a * a) >>> ASH;
    if (alpha > 65535) alpha = 65535;
    o.new_pos_x = np[0][31:0]; o.new_pos_y = np[1][31:0]; o.new_pos_z = np[2][31:0];
    o.new_vel_x = nv[0][31:0]; o.new_vel_y = nv[1][31:0]; o.new_vel_z = nv[2][31:0];
    o.new_age = na[30:0];
    o.alpha = alpha[15:0];
    o.expired = na > life_max;
    return o;
  endfunction

  // Random 32-bit value weighted towards extremes and small magnitudes
  function automatic logic signed [31:0] pick32();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 0;
      3, 4, 5: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick31();
    case ($urandom_range(0, 7))
      0: return 31'h7FFF_FFFF;
      1: return 0;
      2, 3, 4: return 31'($urandom_range(0, 1 << 17));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_item(int wr_pct);
    in_item_t it;
    int k;
    it.command = ($urandom_range(0, 99) < wr_pct) ? CMD_WRITE : CMD_UPDATE;
    it.slot = 3'($urandom);
    it.pos_x = pick32(); it.pos_y = pick32(); it.pos_z = pick32();
    it.vel_x = pick32(); it.vel_y = pick32(); it.vel_z = pick32();
    it.age = pick31();
    it.strength = pick32();
    it.time_step = pick31();
    // Sometimes sit right on an attractor so it is skipped
    if (it.command == CMD_UPDATE && $urandom_range(0, 4) == 0) begin
      k = $urandom_range(0, SLOTS - 1);
      it.pos_x = tab_x[k][31:0]; it.pos_y = tab_y[k][31:0]; it.pos_z = tab_z[k][31:0];
      if ($urandom_range(0, 1)) it.pos_x = it.pos_x + 32'sd1;
    end
    return it;
  endfunction

  function automatic setting_t rand_setting(logic [3:0] cnt);
    setting_t s;
    s.gx = pick32(); s.gy = pick32(); s.gz = pick32();
    s.lin = ($urandom_range(0, 3) == 0) ? pick31() : 31'($urandom_range(0, 1 << 15));
    s.quad = ($urandom_range(0, 3) == 0) ? pick31() : 31'($urandom_range(0, 1 << 12));
    s.life = pick31();
    if (s.life == 0) s.life = 1;
    s.cnt = cnt;
    return s;
  endfunction

  // Write all registers; block must be idle
  task automatic load_setting(setting_t s);
    logic [31:0] vals [7];
    vals[0] = s.gx; vals[1] = s.gy; vals[2] = s.gz;
    vals[3] = {1'b0, s.lin}; vals[4] = {1'b0, s.quad}; vals[5] = {1'b0, s.life};
    vals[6] = {28'd0, s.cnt};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    grav[0] = s.gx; grav[1] = s.gy; grav[2] = s.gz;
    lin_damp = s.lin; quad_damp = s.quad; life_max = s.life;
    att_used = s.cnt;
  endtask

  task automatic drain();
    while (particle_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Offer one item, wait for its transfer, then record the expectation
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (it.command == CMD_WRITE) begin
      tab_x[it.slot] = it.pos_x; tab_y[it.slot] = it.pos_y;
      tab_z[it.slot] = it.pos_z; tab_s[it.slot] = it.strength;
    end else begin
      particle_q.push_back(typed ? want : advance_particle(it));
    end
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int w;
    out_item_t e;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      w = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
      if (hold_req) begin
        hold_req = 1'b0;
        w = HOLD_CYCLES;
      end
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (particle_q.size() == 0) begin
        $error("result transfer with nothing expected");
        nerr++;
      end else begin
        e = particle_q.pop_front();
        if (out_ch.data.new_pos_x !== e.new_pos_x) begin
          $error("new_pos_x exp %0d got %0d", e.new_pos_x, out_ch.data.new_pos_x); nerr++;
        end
        if (out_ch.data.new_pos_y !== e.new_pos_y) begin
          $error("new_pos_y exp %0d got %0d", e.new_pos_y, out_ch.data.new_pos_y); nerr++;
        end
        if (out_ch.data.new_pos_z !== e.new_pos_z) begin
          $error("new_pos_z exp %0d got %0d", e.new_pos_z, out_ch.data.new_pos_z); nerr++;
        end
        if (out_ch.data.new_vel_x !== e.new_vel_x) begin
          $error("new_vel_x exp %0d got %0d", e.new_vel_x, out_ch.data.new_vel_x); nerr++;
        end
        if (out_ch.data.new_vel_y !== e.new_vel_y) begin
          $error("new_vel_y exp %0d got %0d", e.new_vel_y, out_ch.data.new_vel_y); nerr++;
        end
        if (out_ch.data.new_vel_z !== e.new_vel_z) begin
          $error("new_vel_z exp %0d got %0d", e.new_vel_z, out_ch.data.new_vel_z); nerr++;
        end
        if (out_ch.data.new_age !== e.new_age) begin
          $error("new_age exp %0d got %0d", e.new_age, out_ch.data.new_age); nerr++;
        end
        if (out_ch.data.alpha !== e.alpha) begin
          $error("alpha exp %0d got %0d", e.alpha, out_ch.data.alpha); nerr++;
        end
        if (out_ch.data.expired !== e.expired) begin
          $error("expired exp %0d got %0d", e.expired, out_ch.data.expired); nerr++;
        end
      end
    end
  end

  // Directed rows
  task automatic add_row(int ph, logic cmd, logic [2:0] sl, logic signed [31:0] px,
                         logic signed [31:0] py, logic signed [31:0] pz,
                         logic signed [31:0] vx, logic signed [31:0] vy,
                         logic signed [31:0] vz, logic [30:0] ag,
                         logic signed [31:0] st, logic [30:0] dt);
    row_t r;
    r.it = '{cmd, sl, px, py, pz, vx, vy, vz, ag, st, dt};
    r.typed = 1'b0;
    r.want = '0;
    r.ph = ph;
    rows.push_back(r);
  endtask

  initial begin
    setting_t dset, cfg;
    int cur_ph, n;
    logic [3:0] counts [8];
    int sizes [8];
    counts = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd15, 4'd1, 4'd2, 4'd8};
    sizes = '{250, 250, 200, 200, 40, 200, 200, 60};
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_GRAV_X;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    grav[0] = 0; grav[1] = 0; grav[2] = 0;
    lin_damp = 0; quad_damp = 0; life_max = ONE; att_used = 0;
    for (int i = 0; i < SLOTS; i++) begin
      tab_x[i] = 0; tab_y[i] = 0; tab_z[i] = 0; tab_s[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset: still particle, and one saturating its age
    add_row(0, CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    rows[$].typed = 1'b1;
    rows[$].want = '{0, 0, 0, 0, 0, 0, 31'd0, 16'hFFFF, 1'b0};
    add_row(0, CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 0, 31'h7FFF_FFFF);
    rows[$].typed = 1'b1;
    rows[$].want = '{0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 16'hFFFF, 1'b1};
    // Table with far, strong and coincident attractors
    add_row(1, CMD_WRITE, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            0, 0, 0, 0, 32'sh7FFF_FFFF, 0);
    add_row(1, CMD_WRITE, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
            5, 5, 5, 5, 32'sh8000_0000, 5);
    add_row(1, CMD_WRITE, 2, 100 << 16, 0, 0, 0, 0, 0, 0, 1 << 16, 0);
    add_row(1, CMD_WRITE, 3, 0, 3 << 16, 0, 0, 0, 0, 0, -(1 << 18), 0);
    add_row(1, CMD_WRITE, 7, 5 << 16, 5 << 16, 5 << 16, 0, 0, 0, 0, 1 << 20, 0);
    add_row(1, CMD_UPDATE, 5, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
            0, 32'sh1234_5678, 1 << 16);
    add_row(1, CMD_UPDATE, 0, 5 << 16, 5 << 16, 5 << 16, 0, 0, 0, 0, 0, 1000);
    add_row(1, CMD_UPDATE, 7, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
            -1, 31'h7FFF_FFFF);
    add_row(1, CMD_UPDATE, 0, 32'sh7FFF_FFFF, -1, 1, 32'sh8000_0000, 1, -1,
            31'h4000_0000, 0, 31'h7FFF_FFFF);
    add_row(1, CMD_UPDATE, 0, 1 << 16, 1 << 16, 0, 1 << 12, -(1 << 12), 7,
            1 << 15, 0, 1 << 10);
    add_row(1, CMD_UPDATE, 0, (5 << 16) + 3, 5 << 16, 5 << 16, 0, 0, 0, 0, 0, 1 << 16);

    dset.gx = 32'sh7FFF_FFFF; dset.gy = 32'sh8000_0000; dset.gz = 0;
    dset.lin = 31'h8000; dset.quad = 31'h7FFF_FFFF; dset.life = 0; dset.cnt = 4'd8;
    cur_ph = 0;
    foreach (rows[i]) begin
      if (rows[i].ph != cur_ph) begin
        in_ch.valid <= 1'b0;
        drain();
        load_setting(dset);
        cur_ph = rows[i].ph;
      end
      send_item(rows[i].it, rows[i].typed, rows[i].want);
    end

    // Random phases, each under its own setting
    for (int ph = 0; ph < 8; ph++) begin
      in_ch.valid <= 1'b0;
      drain();
      cfg = rand_setting(counts[ph]);
      load_setting(cfg);
      if (ph == 5) hold_req = 1'b1;
      n = 0;
      while (n < sizes[ph]) begin
        send_item(rand_item(30), 1'b0, '0);
        n++;
      end
    end
    in_ch.valid <= 1'b0;

    while (particle_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (nerr == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Run limit
  initial begin
    #40ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
